// ===== design/mm_pkg.sv =====
// Shared types and constants of the matrix multiply block.
package mm_pkg;

    localparam int MM_MAX_DIM    = 8;
    localparam int MM_ELEM_WIDTH = 16;
    localparam int MM_IN_WIDTH   = 16;
    localparam int MM_PROD_WIDTH = 36;
    localparam int MM_DIM_WIDTH  = 4;
    localparam int MM_POS_WIDTH  = 3;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } mm_op_t;

    typedef enum logic [1:0] {
        CFG_ROWS_USED  = 2'd0,
        CFG_INNER_USED = 2'd1,
        CFG_COLS_USED  = 2'd2
    } mm_cfg_index_t;

    typedef struct packed {
        logic [1:0]                    op;
        logic [MM_POS_WIDTH-1:0]       row_index;
        logic [MM_POS_WIDTH-1:0]       col_index;
        logic signed [MM_IN_WIDTH-1:0] element_value;
    } mm_in_t;

    typedef struct packed {
        logic [MM_POS_WIDTH-1:0]         out_row;
        logic [MM_POS_WIDTH-1:0]         out_col;
        logic signed [MM_PROD_WIDTH-1:0] product_value;
        logic                            last;
    } mm_out_t;

endpackage

// ===== design/matrix_multiply.sv =====
// Matrix multiply top level: operand loading, product sequencer and MAC pipeline.
// A compute transfer starts a run that walks every product element; each element is
//   the sum of inner partial products, read through the single read port of each
//   operand memory, and the pipeline stalls while a finished element waits. No new
//   input item is accepted until the run has drained and s_ready rises again.
// Reset: synchronous, active low; dimensions return to MAX_DIM, memories keep contents.
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM    = MM_MAX_DIM,
    parameter int ELEM_WIDTH = MM_ELEM_WIDTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Input item channel.
    input  logic                    s_valid,
    output logic                    s_ready,
    input  mm_in_t                  s_data,
    // Result channel.
    output logic                    m_valid,
    input  logic                    m_ready,
    output mm_out_t                 m_data,
    // Configuration write channel.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [MM_DIM_WIDTH-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = 2 * ELEM_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    // Per-transfer bookkeeping that travels with each partial product.
    typedef struct packed {
        logic [MM_POS_WIDTH-1:0] row;
        logic [MM_POS_WIDTH-1:0] col;
        logic                    first;
        logic                    lastk;
        logic                    last;
    } tag_t;

    // A dimension register holds 0..15; zero acts as one and anything above
    // MAX_DIM acts as MAX_DIM. The result is the highest index to walk.
    function automatic logic [IDX_W-1:0] dim_max(input logic [MM_DIM_WIDTH-1:0] d);
        if (d == '0) begin
            return '0;
        end else if (d > MM_DIM_WIDTH'(MAX_DIM)) begin
            return IDX_W'(MAX_DIM - 1);
        end else begin
            return IDX_W'(d - MM_DIM_WIDTH'(1));
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls.
    // ------------------------------------------------------------------
    logic [MM_DIM_WIDTH-1:0] rows_reg;
    logic [MM_DIM_WIDTH-1:0] inner_reg;
    logic [MM_DIM_WIDTH-1:0] cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= MM_DIM_WIDTH'(MAX_DIM);
            inner_reg <= MM_DIM_WIDTH'(MAX_DIM);
            cols_reg  <= MM_DIM_WIDTH'(MAX_DIM);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROWS_USED:  rows_reg  <= cfg_data;
                CFG_INNER_USED: inner_reg <= cfg_data;
                CFG_COLS_USED:  cols_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [IDX_W-1:0] i_max;
    logic [IDX_W-1:0] k_max;
    logic [IDX_W-1:0] j_max;

    assign i_max = dim_max(rows_reg);
    assign k_max = dim_max(inner_reg);
    assign j_max = dim_max(cols_reg);

    // ------------------------------------------------------------------
    // Input side. Items are taken only while no compute run is in flight,
    // so a load can never overlap a read of the same memory entry.
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic s_xfer;
    logic in_range;
    logic wr_a_en;
    logic wr_b_en;
    logic start;
    logic [ADDR_W-1:0] wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign in_range = (int'(s_data.row_index) < MAX_DIM) && (int'(s_data.col_index) < MAX_DIM);
    assign wr_a_en  = s_xfer && in_range && (s_data.op == OP_LOAD_A);
    assign wr_b_en  = s_xfer && in_range && (s_data.op == OP_LOAD_B);
    assign start    = s_xfer && (s_data.op == OP_COMPUTE);
    assign wr_addr  = ADDR_W'(int'(s_data.row_index) * MAX_DIM + int'(s_data.col_index));
    // The stored element is the low ELEM_WIDTH bits of the sign-extended input.
    assign wr_data  = ELEM_WIDTH'(s_data.element_value);

    // ------------------------------------------------------------------
    // Sequencer. The whole pipeline advances together and freezes while a
    // finished product element waits in the output register.
    // ------------------------------------------------------------------
    logic adv;
    logic issue;
    logic k_end;
    logic j_end;
    logic i_end;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] j_next;
    logic [IDX_W-1:0] k_next;
    tag_t cur_tag;

    logic m_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;

    assign adv   = !m_valid_reg || m_ready;
    assign issue = (state_reg == ST_RUN) && adv;
    assign k_end = (k_reg == k_max);
    assign j_end = (j_reg == j_max);
    assign i_end = (i_reg == i_max);

    always_comb begin
        cur_tag.row   = MM_POS_WIDTH'(i_reg);
        cur_tag.col   = MM_POS_WIDTH'(j_reg);
        cur_tag.first = (k_reg == '0);
        cur_tag.lastk = k_end;
        cur_tag.last  = i_end && j_end && k_end;
    end

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (start) begin
            i_next = '0;
            j_next = '0;
            k_next = '0;
        end else if (issue) begin
            if (!k_end) begin
                k_next = k_reg + IDX_W'(1);
            end else begin
                k_next = '0;
                if (!j_end) begin
                    j_next = j_reg + IDX_W'(1);
                end else begin
                    j_next = '0;
                    i_next = i_reg + IDX_W'(1);
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue && k_end && j_end && i_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!s1_valid_reg && !s2_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // ------------------------------------------------------------------
    // Operand memories. A[i][k] and B[k][j] are read in the same cycle.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [ELEM_WIDTH-1:0] rd_data_a;
    logic [ELEM_WIDTH-1:0] rd_data_b;

    assign rd_addr_a = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign rd_addr_b = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

    mm_operand_mem #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mem (
        .aclk      (aclk),
        .wr_a_en   (wr_a_en),
        .wr_b_en   (wr_b_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (adv),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // ------------------------------------------------------------------
    // Stage 1 holds the read data, stage 2 the registered product, and the
    // accumulator folds stage 2 in. The final term of a dot product goes
    // straight into the output register.
    // ------------------------------------------------------------------
    tag_t s1_tag_reg;
    tag_t s2_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MM_PROD_WIDTH-1:0] acc_reg;
    logic [MM_PROD_WIDTH+PROD_W-1:0] prod_ext;
    logic [MM_PROD_WIDTH-1:0] prod_trim;
    logic [MM_PROD_WIDTH-1:0] acc_sum;
    mm_out_t m_data_reg;

    // The sum is kept modulo 2^36, which gives the exact low bits of the result.
    assign prod_ext  = {{MM_PROD_WIDTH{prod_reg[PROD_W-1]}}, prod_reg};
    assign prod_trim = prod_ext[MM_PROD_WIDTH-1:0];
    assign acc_sum   = (s2_tag_reg.first ? '0 : acc_reg) + prod_trim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
            end
            m_valid_reg <= (m_valid_reg && !m_ready) ||
                           (adv && s2_valid_reg && s2_tag_reg.lastk);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= cur_tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= $signed(rd_data_a) * $signed(rd_data_b);
            if (s2_valid_reg) begin
                acc_reg <= acc_sum;
            end
            if (s2_valid_reg && s2_tag_reg.lastk) begin
                m_data_reg.out_row       <= s2_tag_reg.row;
                m_data_reg.out_col       <= s2_tag_reg.col;
                m_data_reg.product_value <= acc_sum;
                m_data_reg.last          <= s2_tag_reg.last;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // While idle no partial product may remain in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("pipeline not empty while idle");

    // An accepted compute transfer starts the sequencer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.op == OP_COMPUTE)) |=> (state_reg == ST_RUN))
        else $error("compute transfer did not start a run");

    // A stalled product stage keeps its value until the output drains.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!adv && s2_valid_reg) |=> (s2_valid_reg && $stable(prod_reg)))
        else $error("product stage changed during a stall");

    // The last element of a run is always the last term of its dot product.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_tag_reg.last) |-> s2_tag_reg.lastk)
        else $error("run end tag without dot product end");

endmodule

// ===== design/mm_operand_mem.sv =====
// Operand stores for matrices A and B: one write port, one registered read port each.
module mm_operand_mem
    import mm_pkg::*;
#(
    parameter int MAX_DIM    = MM_MAX_DIM,
    parameter int ELEM_WIDTH = MM_ELEM_WIDTH,
    localparam int DEPTH     = MAX_DIM * MAX_DIM,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  wr_a_en,
    input  logic                  wr_b_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [ELEM_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr_a,
    input  logic [ADDR_W-1:0]     rd_addr_b,
    output logic [ELEM_WIDTH-1:0] rd_data_a,
    output logic [ELEM_WIDTH-1:0] rd_data_b
);

    logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
    logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_a_en) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_b_en) begin
            mem_b[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_b <= mem_b[rd_addr_b];
        end
    end

endmodule
